// ----- hw/rtl/lcdseq_pkg.sv -----
// lcdseq_pkg: types, codes and constants shared by the lcd expander byte sequencer
// no dependencies
`default_nettype none

package lcdseq_pkg;

  // operation codes of an input item
  localparam logic OP_CODE = 1'b0;
  localparam logic OP_POS  = 1'b1;

  // configuration register indexes
  localparam logic REG_BACKLIGHT   = 1'b0;
  localparam logic REG_NIBBLE_MODE = 1'b1;

  // shadow bit positions
  localparam logic [2:0] SH_RS = 3'd0;
  localparam logic [2:0] SH_RW = 3'd1;
  localparam logic [2:0] SH_EN = 3'd2;
  localparam logic [2:0] SH_D7 = 3'd6;

  // sequencer step numbers
  localparam logic [3:0] STEP_RS       = 4'd0;
  localparam logic [3:0] STEP_RW       = 4'd1;
  localparam logic [3:0] STEP_EN_LO    = 4'd2;
  localparam logic [3:0] STEP_HI_FIRST = 4'd3;
  localparam logic [3:0] STEP_HI_LAST  = 4'd6;
  localparam logic [3:0] STEP_MID_HI   = 4'd7;
  localparam logic [3:0] STEP_MID_LO   = 4'd8;
  localparam logic [3:0] STEP_LO_FIRST = 4'd9;
  localparam logic [3:0] STEP_LO_LAST  = 4'd12;
  localparam logic [3:0] STEP_FIN_HI   = 4'd13;
  localparam logic [3:0] STEP_FIN_LO   = 4'd14;

  localparam logic [7:0] SET_DDRAM = 8'b1000_0000;

  typedef struct packed {
    logic       op;
    logic       reg_select;
    logic [7:0] code;
    logic [5:0] column;
    logic [2:0] row;
  } in_item_t;

  typedef struct packed {
    logic [7:0] expander_byte;
    logic       last;
  } out_item_t;

  // one queued write: rs level and code byte
  typedef struct packed {
    logic       rs;
    logic [7:0] code;
  } seq_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [6:0] row_base(input logic [1:0] row);
    logic [6:0] b;
    unique case (row)
      2'd0:    b = 7'd0;
      2'd1:    b = 7'd64;
      2'd2:    b = 7'd20;
      default: b = 7'd84;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/lcdseq_front.sv -----
// lcdseq_front: classifies input items into queued code writes
// depends on lcdseq_pkg
`default_nettype none

module lcdseq_front (
  input  lcdseq_pkg::in_item_t item_i,
  input  logic                 valid_i,
  input  lcdseq_pkg::q_status_t q_status_i,
  output logic                 stall_o,
  output logic                 push_o,
  output lcdseq_pkg::seq_cmd_t cmd_o
);
  import lcdseq_pkg::*;

  logic [7:0] addr;
  logic       drop;

  // row base plus column, kept to 8 bits
  assign addr = 8'(row_base(item_i.row[1:0])) + {2'b00, item_i.column};
  // rows four to seven produce nothing
  assign drop = (item_i.op == OP_POS) && item_i.row[2];

  always_comb begin
    unique case (item_i.op)
      OP_CODE: begin
        cmd_o.rs   = item_i.reg_select;
        cmd_o.code = item_i.code;
      end
      default: begin
        cmd_o.rs   = 1'b0;
        cmd_o.code = SET_DDRAM | addr;
      end
    endcase
  end

  assign stall_o = q_status_i.full;
  assign push_o  = valid_i && !q_status_i.full && !drop;

endmodule

`default_nettype wire

// ----- hw/rtl/lcdseq_queue.sv -----
// lcdseq_queue: short fifo of code writes between front and back
// depends on lcdseq_pkg
`default_nettype none

module lcdseq_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  lcdseq_pkg::seq_cmd_t  cmd_i,
  input  logic                  pop_i,
  output lcdseq_pkg::seq_cmd_t  cmd_o,
  output lcdseq_pkg::q_status_t status_o
);
  import lcdseq_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  seq_cmd_t        mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    logic [PW-1:0] n;
    if (p == PW'(DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + PW'(1);
    end
    return n;
  endfunction

  assign status_o.full  = (count_q == CW'(DEPTH));
  assign status_o.empty = (count_q == '0);
  assign cmd_o          = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CW'(push_i) - CW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lcdseq_back.sv -----
// lcdseq_back: steps the pin shadow one line change per cycle, unless the output stalls, into the output register
// depends on lcdseq_pkg
`default_nettype none

module lcdseq_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  backlight_i,
  input  logic                  nibble_mode_i,
  input  lcdseq_pkg::seq_cmd_t  cmd_i,
  input  lcdseq_pkg::q_status_t q_status_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output lcdseq_pkg::out_item_t out_item_o
);
  import lcdseq_pkg::*;

  logic      busy_q, busy_d;
  logic [3:0] step_q, step_d;
  seq_cmd_t  cmd_q, cmd_d;
  logic [6:0] shadow_q, shadow_d;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  logic       advance;
  logic       last_step;
  logic [2:0] pin;
  logic       level;
  logic       touch;

  assign advance   = busy_q && (!out_valid_q || !out_stall_i);
  assign last_step = (step_q == STEP_FIN_LO) || ((step_q == STEP_MID_LO) && !nibble_mode_i);
  assign pop_o     = !q_status_i.empty && (!busy_q || (advance && last_step));

  // which line this step drives and to what level
  always_comb begin
    pin   = SH_EN;
    level = 1'b0;
    touch = 1'b1;
    priority if (step_q == STEP_RS) begin
      pin   = SH_RS;
      level = cmd_q.rs;
    end else if (step_q == STEP_RW) begin
      pin = SH_RW;
    end else if (step_q == STEP_EN_LO || step_q == STEP_MID_LO || step_q == STEP_FIN_LO) begin
      pin = SH_EN;
    end else if (step_q == STEP_MID_HI || step_q == STEP_FIN_HI) begin
      pin   = SH_EN;
      level = 1'b1;
    end else if (step_q >= STEP_HI_FIRST && step_q <= STEP_HI_LAST) begin
      // D7 first, high nibble
      pin   = SH_D7 - 3'(step_q - STEP_HI_FIRST);
      level = cmd_q.code[3'd7 - 3'(step_q - STEP_HI_FIRST)];
    end else if (step_q >= STEP_LO_FIRST && step_q <= STEP_LO_LAST) begin
      pin   = SH_D7 - 3'(step_q - STEP_LO_FIRST);
      level = cmd_q.code[3'd3 - 3'(step_q - STEP_LO_FIRST)];
    end else begin
      touch = 1'b0;
    end
  end

  always_comb begin
    shadow_d = shadow_q;
    if (advance && touch) begin
      shadow_d[pin] = level;
    end
  end

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    cmd_d  = cmd_q;
    if (pop_o) begin
      busy_d = 1'b1;
      step_d = STEP_RS;
      cmd_d  = cmd_i;
    end else if (advance && last_step) begin
      busy_d = 1'b0;
    end else if (advance) begin
      step_d = step_q + 4'd1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (advance) begin
      out_valid_d         = 1'b1;
      out_d.expander_byte = {shadow_d[6:3], backlight_i, shadow_d[2:0]};
      out_d.last          = last_step;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= STEP_RS;
      shadow_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      step_q      <= step_d;
      shadow_q    <= shadow_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lcd_i2c_expander_byte_sequencer_unit.sv -----
// lcd_i2c_expander_byte_sequencer_unit: top level of the lcd expander byte sequencer
// depends on lcdseq_pkg, lcdseq_front, lcdseq_queue, lcdseq_back
`default_nettype none

// Turns lcd controller writes (code bytes or cursor positions) into the stream of
// 8-bit expander pin images {D7..D4, backlight, EN, RW, RS}, one per line change.
// A code or position item yields 15 bytes in nibble mode and 9 bytes otherwise, the
// final one flagged by last; a position item on rows four to seven yields nothing.
// The back sequencer emits one byte per cycle when the output is not stalled, and
// items follow back to back while the next one is already queued; that single step
// counter sets the rate. The front classifies an item in the cycle it
// is accepted and parks it in a QUEUE_DEPTH-entry queue, so input is taken while
// the back is still busy; input stalls only when the queue is full. Configuration
// writes are meant for idle periods and take effect at once.

module lcd_i2c_expander_byte_sequencer_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic                  cfg_data_i,
  // item input
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  lcdseq_pkg::in_item_t  in_item_i,
  // byte output
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output lcdseq_pkg::out_item_t out_item_o
);
  import lcdseq_pkg::*;

  // configuration registers
  logic backlight_q, backlight_d;
  logic nibble_mode_q, nibble_mode_d;

  // front to queue to back
  logic      push;
  logic      pop;
  seq_cmd_t  front_cmd;
  seq_cmd_t  queue_cmd;
  q_status_t q_status;

  always_comb begin
    backlight_d   = backlight_q;
    nibble_mode_d = nibble_mode_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BACKLIGHT:   backlight_d   = cfg_data_i;
        REG_NIBBLE_MODE: nibble_mode_d = cfg_data_i;
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      backlight_q   <= 1'b1;
      nibble_mode_q <= 1'b1;
    end else begin
      backlight_q   <= backlight_d;
      nibble_mode_q <= nibble_mode_d;
    end
  end

  // classify: code write or cursor position, drop rows four to seven
  lcdseq_front u_front (
    .item_i     (in_item_i),
    .valid_i    (in_valid_i),
    .q_status_i (q_status),
    .stall_o    (in_stall_o),
    .push_o     (push),
    .cmd_o      (front_cmd)
  );

  // decouples front from back
  lcdseq_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (front_cmd),
    .pop_i    (pop),
    .cmd_o    (queue_cmd),
    .status_o (q_status)
  );

  // line-by-line sequencer with output register
  lcdseq_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .backlight_i   (backlight_q),
    .nibble_mode_i (nibble_mode_q),
    .cmd_i         (queue_cmd),
    .q_status_i    (q_status),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_item_o    (out_item_o)
  );

`ifndef SYNTHESIS
  // never push into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push && q_status.full))
    else $error("push into full queue");

  // never pop an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(pop && q_status.empty))
    else $error("pop from empty queue");

  // every sequence ends with EN low
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.last |-> !out_item_o.expander_byte[2])
    else $error("final byte with EN high");

  // RW is only ever driven low
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !out_item_o.expander_byte[1])
    else $error("RW high in emitted byte");
`endif

endmodule

`default_nettype wire
